// File: rtl/psu_pkg.sv
package psu_pkg;

  // Input item: operation selects load or read request.
  typedef struct packed {
    logic       operation;
    logic [7:0] packed_byte;
  } psu_in_t;

  // Result item: one decoded sample.
  typedef struct packed {
    logic signed [7:0] sample;
    logic              last_sample;
  } psu_out_t;

  // Operation codes
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_READ = 1'b1;

  // Configuration register indexes
  localparam logic CFG_ESCAPE = 1'b0;
  localparam logic CFG_LENGTH = 1'b1;

  // Delta code that keeps its magnitude of 128
  localparam logic [7:0] CODE_NEG_MAX = 8'h80;
  localparam logic [7:0] MASK_START   = 8'h80;

  // Status of the bit-plane sequencer as seen by the controller.
  typedef struct packed {
    logic busy;
    logic done;
  } psu_rg_status_t;

  // Rotate right of an 8-bit value; shifts of 8 and above act as a plain shift
  // of the doubled word.
  function automatic logic [7:0] rot_right8(input logic [7:0] v, input logic [3:0] s);
    logic [15:0] w;
    w = {v, v} >> s;
    return w[7:0];
  endfunction

endpackage

// File: rtl/psu_ram.sv
module psu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: rtl/psu_rle_loader.sv
module psu_rle_loader import psu_pkg::*; #(
  parameter int MAX_BLOCK = 65536
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         load_en,
  input  logic [7:0]                   load_byte,
  input  logic [7:0]                   escape_byte,
  input  logic [$clog2(MAX_BLOCK+1)-1:0] blk_len,
  input  logic                         clear,
  output logic                         busy,
  output logic                         run_we,
  output logic [$clog2(MAX_BLOCK)-1:0] run_waddr,
  output logic [7:0]                   run_wdata,
  output logic [$clog2(MAX_BLOCK+1)-1:0] fill
);

  localparam int AW = $clog2(MAX_BLOCK);
  localparam int CW = $clog2(MAX_BLOCK + 1);

  typedef enum logic [1:0] {
    L_IDLE = 2'b01,
    L_RUN  = 2'b10
  } ldr_state_t;

  typedef enum logic [2:0] {
    PH_NONE = 3'b001,
    PH_ESC  = 3'b010,
    PH_CNT  = 3'b100
  } esc_phase_t;

  ldr_state_t      state_r, state_nxt;
  esc_phase_t      phase_r, phase_nxt;
  logic [7:0]      cnt_r, cnt_nxt;
  logic [7:0]      val_r, val_nxt;
  logic [7:0]      rem_r, rem_nxt;
  logic [CW-1:0]   widx_r, widx_nxt;
  logic            put;
  logic [7:0]      put_byte;

  always_comb begin
    state_nxt = state_r;
    phase_nxt = phase_r;
    cnt_nxt   = cnt_r;
    val_nxt   = val_r;
    rem_nxt   = rem_r;
    put       = 1'b0;
    put_byte  = load_byte;
    case (state_r)
      L_IDLE: begin
        if (load_en) begin
          case (phase_r)
            PH_ESC: begin
              if (load_byte == 8'h00) begin
                put       = 1'b1;
                put_byte  = escape_byte;
                phase_nxt = PH_NONE;
              end else begin
                cnt_nxt   = load_byte;
                phase_nxt = PH_CNT;
              end
            end
            PH_CNT: begin
              val_nxt   = load_byte;
              rem_nxt   = cnt_r;
              phase_nxt = PH_NONE;
              state_nxt = L_RUN;
            end
            default: begin
              if (load_byte == escape_byte) begin
                phase_nxt = PH_ESC;
              end else begin
                put = 1'b1;
              end
            end
          endcase
        end
      end
      L_RUN: begin
        put      = 1'b1;
        put_byte = val_r;
        rem_nxt  = rem_r - 8'd1;
        // stop early once the block is full; remaining repeats are dropped
        if (rem_r == 8'd1 || widx_r >= blk_len) begin
          state_nxt = L_IDLE;
        end
      end
      default: state_nxt = L_IDLE;
    endcase
  end

  assign run_we    = put && (widx_r < blk_len);
  assign run_waddr = widx_r[AW-1:0];
  assign run_wdata = put_byte;
  assign widx_nxt  = run_we ? widx_r + CW'(1) : widx_r;

  always_ff @(posedge clk) begin
    if (!rst_n || clear) begin
      state_r <= L_IDLE;
      phase_r <= PH_NONE;
      cnt_r   <= '0;
      widx_r  <= '0;
    end else begin
      state_r <= state_nxt;
      phase_r <= phase_nxt;
      cnt_r   <= cnt_nxt;
      widx_r  <= widx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
    rem_r <= rem_nxt;
  end

  assign busy = (state_r == L_RUN);
  assign fill = widx_r;

endmodule

// File: rtl/psu_plane_regroup.sv
module psu_plane_regroup import psu_pkg::*; #(
  parameter int MAX_BLOCK = 65536
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic [$clog2(MAX_BLOCK+1)-1:0] blk_len,
  input  logic [$clog2(MAX_BLOCK+1)-1:0] fill,
  output logic                           run_re,
  output logic [$clog2(MAX_BLOCK)-1:0]   run_raddr,
  input  logic [7:0]                     run_rdata,
  output logic                           plane_re,
  output logic [$clog2(MAX_BLOCK)-1:0]   plane_raddr,
  input  logic [7:0]                     plane_rdata,
  output logic                           plane_we,
  output logic [$clog2(MAX_BLOCK)-1:0]   plane_waddr,
  output logic [7:0]                     plane_wdata,
  output psu_rg_status_t                 status
);

  localparam int AW = $clog2(MAX_BLOCK);
  localparam int CW = $clog2(MAX_BLOCK + 1);

  typedef enum logic [3:0] {
    R_IDLE  = 4'b0001,
    R_FETCH = 4'b0010,
    R_BITS  = 4'b0100,
    R_DRAIN = 4'b1000
  } rg_state_t;

  rg_state_t     state_r, state_nxt;
  logic [AW-1:0] i_r, i_nxt;
  logic [AW-1:0] k_r, k_nxt;
  logic [2:0]    bit_r, bit_nxt;
  logic [3:0]    wraps_r, wraps_nxt;
  logic [7:0]    mask_r, mask_nxt;
  logic          wrapped_r, wrapped_nxt;
  logic          src_ok_r;

  // write stage of the read-modify-write
  logic          wv_r;
  logic [AW-1:0] waddr_r;
  logic [7:0]    contrib_r;
  logic          first_r;
  logic          fwd_hit_r;
  logic [7:0]    fwd_data_r;

  logic [7:0]    src;
  logic [2:0]    shift3;
  logic [7:0]    contrib;
  logic [CW-1:0] k_inc, i_inc;
  logic          k_wrap;
  logic [3:0]    wraps_inc;
  logic [7:0]    mask_rot1;
  logic [7:0]    old_val;
  logic          issue;

  assign src       = src_ok_r ? run_rdata : 8'h00;
  assign shift3    = wraps_r[2:0] - bit_r;
  assign contrib   = rot_right8(src & mask_r, {1'b0, shift3});
  assign k_inc     = CW'(k_r) + CW'(1);
  assign k_wrap    = (k_inc >= blk_len);
  assign wraps_inc = wraps_r + {3'b000, k_wrap};
  assign mask_rot1 = rot_right8(mask_r, 4'd1);
  assign i_inc     = CW'(i_r) + CW'(1);
  assign issue     = (state_r == R_BITS);

  always_comb begin
    state_nxt   = state_r;
    i_nxt       = i_r;
    k_nxt       = k_r;
    bit_nxt     = bit_r;
    wraps_nxt   = wraps_r;
    mask_nxt    = mask_r;
    wrapped_nxt = wrapped_r;
    case (state_r)
      R_IDLE: begin
        if (start) begin
          i_nxt       = '0;
          k_nxt       = '0;
          mask_nxt    = MASK_START;
          wrapped_nxt = 1'b0;
          state_nxt   = R_FETCH;
        end
      end
      R_FETCH: begin
        bit_nxt   = 3'd0;
        wraps_nxt = 4'd0;
        state_nxt = R_BITS;
      end
      R_BITS: begin
        k_nxt       = k_wrap ? '0 : k_inc[AW-1:0];
        wraps_nxt   = wraps_inc;
        wrapped_nxt = wrapped_r | k_wrap;
        bit_nxt     = bit_r + 3'd1;
        mask_nxt    = mask_rot1;
        if (bit_r == 3'd7) begin
          // per-byte re-rotation by the number of wraps inside this byte
          mask_nxt = rot_right8(mask_rot1, wraps_inc);
          if (i_inc >= blk_len) begin
            state_nxt = R_DRAIN;
          end else begin
            i_nxt     = i_inc[AW-1:0];
            state_nxt = R_FETCH;
          end
        end
      end
      R_DRAIN: state_nxt = R_IDLE;
      default: state_nxt = R_IDLE;
    endcase
  end

  // first visit of an entry ignores stale contents from a previous block
  assign old_val     = first_r ? 8'h00 : (fwd_hit_r ? fwd_data_r : plane_rdata);
  assign plane_we    = wv_r;
  assign plane_waddr = waddr_r;
  assign plane_wdata = contrib_r | old_val;

  assign plane_re    = issue;
  assign plane_raddr = k_r;
  assign run_re      = (state_r == R_FETCH);
  assign run_raddr   = i_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= R_IDLE;
      wv_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      wv_r    <= issue;
    end
  end

  always_ff @(posedge clk) begin
    i_r       <= i_nxt;
    k_r       <= k_nxt;
    bit_r     <= bit_nxt;
    wraps_r   <= wraps_nxt;
    mask_r    <= mask_nxt;
    wrapped_r <= wrapped_nxt;
    if (state_r == R_FETCH) begin
      src_ok_r <= (CW'(i_r) < fill);
    end
    if (issue) begin
      waddr_r    <= k_r;
      contrib_r  <= contrib;
      first_r    <= !wrapped_r;
      // read issued while the same entry is being written this cycle
      fwd_hit_r  <= wv_r && (waddr_r == k_r);
      fwd_data_r <= plane_wdata;
    end
  end

  assign status.busy = (state_r != R_IDLE);
  assign status.done = (state_r == R_DRAIN);

endmodule

// File: rtl/packed_sample_unpacker_core.sv
// Packed sample block unpacker.
// Input channel (in_valid/in_stall/in_data): operation OP_LOAD feeds one packed
// byte, run-length decoded into the run memory; OP_READ requests one sample.
// A load transaction that ends a run keeps in_stall high while the repeats
// of the run are written.
// Loads arriving after the block has been regrouped are dropped.
// The first request of a block regroups bit planes from the run memory into
// the plane memory: per sample byte, one run-memory fetch plus eight
// read-modify-write bit steps on the plane memory.
// Later requests go through plane read, delta decode and the output register.
// Output channel (out_valid/out_stall/out_data) holds a result register; while
// it waits under stall, the block still takes load transactions, but a
// request finishes only once the register is free. Config port is always
// ready and must be written only while the block is idle.
// Reset (rst_n low, synchronous) clears control state and registers to
// escape 0, length 1. Memories are not cleared: a fill count and a first-visit
// flag stand in for clearing, so no sweep is needed after reset.
module packed_sample_unpacker_core import psu_pkg::*; #(
  parameter int MAX_BLOCK = 65536
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  psu_in_t     in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output psu_out_t    out_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [16:0] cfg_data
);

  localparam int AW = $clog2(MAX_BLOCK);
  localparam int CW = $clog2(MAX_BLOCK + 1);

  typedef enum logic [3:0] {
    T_IDLE    = 4'b0001,
    T_REGROUP = 4'b0010,
    T_FETCH   = 4'b0100,
    T_DELTA   = 4'b1000
  } top_state_t;

  // configuration
  logic [7:0]  escape_r;
  logic [16:0] out_length_r;
  logic [CW-1:0] blk_len;

  // control
  top_state_t    state_r, state_nxt;
  logic          unpacked_r;
  logic          start_r;
  logic [CW-1:0] plane_len_r;
  logic [AW-1:0] read_idx_r;
  logic [7:0]    acc_r;
  logic          out_valid_r;
  psu_out_t      out_data_r;

  logic          in_acc;
  logic          load_en;
  logic          req_en;
  logic          out_free;
  logic          emit;
  logic          last;
  logic          clear_blk;
  logic [7:0]    code;
  logic [7:0]    acc_nxt;

  // sub-unit wiring
  logic          ldr_busy;
  logic          run_we;
  logic [AW-1:0] run_waddr;
  logic [7:0]    run_wdata;
  logic [CW-1:0] fill;
  logic          run_re;
  logic [AW-1:0] run_raddr;
  logic [7:0]    run_rdata;
  logic          rg_plane_re;
  logic [AW-1:0] rg_plane_raddr;
  logic          plane_re;
  logic [AW-1:0] plane_raddr;
  logic [7:0]    plane_rdata;
  logic          plane_we;
  logic [AW-1:0] plane_waddr;
  logic [7:0]    plane_wdata;
  psu_rg_status_t rg_status;

  // config writes
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      escape_r     <= 8'h00;
      out_length_r <= 17'd1;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_ESCAPE: escape_r     <= cfg_data[7:0];
        CFG_LENGTH: out_length_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // effective block length: zero reads as one, clamp at the memory depth
  always_comb begin
    if (out_length_r == 17'd0) begin
      blk_len = CW'(1);
    end else if (32'(out_length_r) > 32'(MAX_BLOCK)) begin
      blk_len = CW'(MAX_BLOCK);
    end else begin
      blk_len = CW'(out_length_r);
    end
  end

  // input handshake: one transaction at a time, loads ride over a busy output
  assign in_stall = !((state_r == T_IDLE) && !ldr_busy);
  assign in_acc   = in_valid && !in_stall;
  assign load_en  = in_acc && (in_data.operation == OP_LOAD) && !unpacked_r;
  assign req_en   = in_acc && (in_data.operation == OP_READ);

  // delta decode; entries past the regrouped length read as zero
  assign out_free = !out_valid_r || !out_stall;
  assign emit     = (state_r == T_DELTA) && out_free;
  assign code     = (CW'(read_idx_r) < plane_len_r) ? plane_rdata : 8'h00;
  assign last     = (CW'(read_idx_r) + CW'(1)) >= blk_len;
  assign clear_blk = emit && last;

  always_comb begin
    if (code != CODE_NEG_MAX && code[7]) begin
      acc_nxt = acc_r + {1'b0, code[6:0]};
    end else begin
      acc_nxt = acc_r - code;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      T_IDLE: begin
        if (req_en) begin
          state_nxt = unpacked_r ? T_FETCH : T_REGROUP;
        end
      end
      T_REGROUP: if (rg_status.done) state_nxt = T_FETCH;
      T_FETCH:   state_nxt = T_DELTA;
      T_DELTA:   if (out_free) state_nxt = T_IDLE;
      default:   state_nxt = T_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= T_IDLE;
      unpacked_r  <= 1'b0;
      start_r     <= 1'b0;
      read_idx_r  <= '0;
      acc_r       <= 8'h00;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      start_r <= req_en && !unpacked_r;
      if (req_en) begin
        unpacked_r <= 1'b1;
      end
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (clear_blk) begin
        // block done: back to the reset state, config kept
        unpacked_r <= 1'b0;
        read_idx_r <= '0;
        acc_r      <= 8'h00;
      end else if (emit) begin
        read_idx_r <= read_idx_r + AW'(1);
        acc_r      <= acc_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req_en && !unpacked_r) begin
      plane_len_r <= blk_len;
    end
    if (emit) begin
      out_data_r.sample      <= acc_nxt;
      out_data_r.last_sample <= last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // plane memory read port: sequencer while regrouping, else sample fetch
  assign plane_re    = rg_plane_re || (state_r == T_FETCH);
  assign plane_raddr = rg_plane_re ? rg_plane_raddr : read_idx_r;

  psu_rle_loader #(
    .MAX_BLOCK (MAX_BLOCK)
  ) u_loader (
    .clk         (clk),
    .rst_n       (rst_n),
    .load_en     (load_en),
    .load_byte   (in_data.packed_byte),
    .escape_byte (escape_r),
    .blk_len     (blk_len),
    .clear       (clear_blk),
    .busy        (ldr_busy),
    .run_we      (run_we),
    .run_waddr   (run_waddr),
    .run_wdata   (run_wdata),
    .fill        (fill)
  );

  psu_plane_regroup #(
    .MAX_BLOCK (MAX_BLOCK)
  ) u_regroup (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start_r),
    .blk_len     (plane_len_r),
    .fill        (fill),
    .run_re      (run_re),
    .run_raddr   (run_raddr),
    .run_rdata   (run_rdata),
    .plane_re    (rg_plane_re),
    .plane_raddr (rg_plane_raddr),
    .plane_rdata (plane_rdata),
    .plane_we    (plane_we),
    .plane_waddr (plane_waddr),
    .plane_wdata (plane_wdata),
    .status      (rg_status)
  );

  psu_ram #(
    .WIDTH (8),
    .DEPTH (MAX_BLOCK)
  ) u_run_ram (
    .clk   (clk),
    .we    (run_we),
    .waddr (run_waddr),
    .wdata (run_wdata),
    .re    (run_re),
    .raddr (run_raddr),
    .rdata (run_rdata)
  );

  psu_ram #(
    .WIDTH (8),
    .DEPTH (MAX_BLOCK)
  ) u_plane_ram (
    .clk   (clk),
    .we    (plane_we),
    .waddr (plane_waddr),
    .wdata (plane_wdata),
    .re    (plane_re),
    .raddr (plane_raddr),
    .rdata (plane_rdata)
  );

endmodule
